// ===== src/gcb_pkg.sv =====
package gcb_pkg;

	localparam int MAX_ROWS  = 16;
	localparam int DEF_NODES = 16;
	localparam int CNT_W     = 5;
	localparam int COLOR_W   = 4;
	localparam int NODE_W    = 4;
	localparam int ROW_W     = 16;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;
	localparam int IN_DW     = 24;
	localparam int OUT_DW    = 8;

	localparam logic [CNT_W-1:0] RST_COLORS = CNT_W'(3);
	localparam logic [CNT_W-1:0] RST_NODES  = CNT_W'(4);
	localparam logic [CNT_W-1:0] MAX_COLORS = CNT_W'(16);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic REG_COLORS = 1'b0;
	localparam logic REG_NODES  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] colors;
		logic [CNT_W-1:0] nodes;
	} limits_t;

	typedef struct packed {
		logic               valid;
		logic               found;
		logic [NODE_W-1:0]  node;
		logic [COLOR_W-1:0] color;
		logic               last;
	} result_t;

endpackage

// ===== src/graph_coloring_backtrack.sv =====
// A load word yields no result; the next word can be taken in the following cycle.
// A solve word runs the search, one colour trial or backtrack step at a time, then emits its
// result words (node_count words, or one failure word), each waiting until the output takes it.
// The search loop and its single colour-conflict compare unit set the pace; no word is taken
// meanwhile. Reset clears the adjacency matrix at once and sets the colour and node counts to
// three and four; there is no clearing pass.
module graph_coloring_backtrack
	import gcb_pkg::*;
#(
	parameter int NODES = DEF_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,  // row_index [3:0], row_bits [19:4]
	input  logic              s_tuser,  // operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,  // node [3:0], color [7:4]
	output logic              m_tuser,  // found
	output logic              m_tlast
);

	limits_t lim;
	result_t res;

	logic                m_valid_q;
	logic                found_q;
	logic                last_q;
	logic [NODE_W-1:0]   node_q;
	logic [COLOR_W-1:0]  color_q;
	logic                take;

	gcb_cfg #(
		.NODES (NODES)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lim     (lim)
	);

	gcb_search #(
		.NODES (NODES)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.lim      (lim),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_row   (s_tdata[NODE_W-1:0]),
		.in_bits  (s_tdata[NODE_W+ROW_W-1:NODE_W]),
		.res      (res),
		.res_take (take)
	);

	assign take = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			found_q <= res.found;
			node_q  <= res.node;
			color_q <= res.color;
			last_q  <= res.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {color_q, node_q};
	assign m_tuser  = found_q;
	assign m_tlast  = last_q;

endmodule

// ===== src/gcb_cfg.sv =====
module gcb_cfg
	import gcb_pkg::*;
#(
	parameter int NODES = DEF_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output limits_t           lim
);

	localparam int ROWS = (NODES < MAX_ROWS) ? NODES : MAX_ROWS;
	localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

	logic [CNT_W-1:0] colors_q;
	logic [CNT_W-1:0] nodes_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q <= RST_COLORS;
			nodes_q  <= RST_NODES;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_COLORS: colors_q <= pwdata[CNT_W-1:0];
				REG_NODES:  nodes_q  <= pwdata[CNT_W-1:0];
				default:    colors_q <= colors_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COLORS: prdata = CFG_DW'(colors_q);
			REG_NODES:  prdata = CFG_DW'(nodes_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		lim.colors = (colors_q > MAX_COLORS) ? MAX_COLORS : colors_q;
		if (nodes_q == '0) begin
			lim.nodes = CNT_W'(1);
		end else if (nodes_q > ROWS_C) begin
			lim.nodes = ROWS_C;
		end else begin
			lim.nodes = nodes_q;
		end
	end

endmodule

// ===== src/gcb_fit.sv =====
module gcb_fit
	import gcb_pkg::*;
#(
	parameter int ROWS = MAX_ROWS,
	parameter int DW   = $clog2(MAX_ROWS + 1)
) (
	input  logic [ROWS-1:0]              col,
	input  logic [ROWS-1:0][COLOR_W-1:0] stack,
	input  logic [DW-1:0]                depth,
	input  logic [CNT_W-1:0]             cand,
	output logic                         fits
);

	logic [ROWS-1:0] hit;

	always_comb begin
		for (int p = 0; p < ROWS; p++) begin
			hit[p] = col[p] && (DW'(p) < depth) && (CNT_W'(stack[p]) == cand);
		end
		fits = ~|hit;
	end

endmodule

// ===== src/gcb_search.sv =====
module gcb_search
	import gcb_pkg::*;
#(
	parameter int NODES = DEF_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  limits_t           lim,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_op,
	input  logic [NODE_W-1:0] in_row,
	input  logic [ROW_W-1:0]  in_bits,
	output result_t           res,
	input  logic              res_take
);

	localparam int ROWS = (NODES < MAX_ROWS) ? NODES : MAX_ROWS;
	localparam int IW   = $clog2(ROWS);
	localparam int DW   = $clog2(ROWS + 1);

	state_t state_q, state_d;

	logic [DW-1:0]    d_q;
	logic [CNT_W-1:0] cand_q;
	logic [IW-1:0]    k_q;
	logic             fail_q;

	logic [ROWS-1:0]              adj_q [ROWS];
	logic [ROWS-1:0][COLOR_W-1:0] stack_q;
	logic [CNT_W-1:0]             used_q [ROWS+1];

	logic [ROWS-1:0]    col;
	logic [CNT_W-1:0]   used_cur;
	logic [CNT_W:0]     top_w;
	logic [CNT_W-1:0]   top;
	logic [CNT_W-1:0]   cand_inc;
	logic [CNT_W-1:0]   used_new;
	logic [DW-1:0]      d_dec;
	logic [IW-1:0]      rd_idx;
	logic [COLOR_W-1:0] rd_color;
	logic               at_end;
	logic               exhausted;
	logic               fits;
	logic               accept;

	gcb_fit #(
		.ROWS (ROWS),
		.DW   (DW)
	) u_fit (
		.col   (col),
		.stack (stack_q),
		.depth (d_q),
		.cand  (cand_q),
		.fits  (fits)
	);

	always_comb begin
		for (int p = 0; p < ROWS; p++) begin
			col[p] = adj_q[p][d_q[IW-1:0]];
		end
		used_cur  = (d_q == '0) ? '0 : used_q[d_q];
		top_w     = {1'b0, used_cur} + (CNT_W+1)'(1);
		top       = (top_w > {1'b0, lim.colors}) ? lim.colors : top_w[CNT_W-1:0];
		cand_inc  = cand_q + CNT_W'(1);
		used_new  = (cand_inc > used_cur) ? cand_inc : used_cur;
		d_dec     = d_q - DW'(1);
		rd_idx    = (state_q == ST_EMIT) ? k_q : d_dec[IW-1:0];
		rd_color  = stack_q[rd_idx];
		at_end    = (CNT_W'(d_q) == lim.nodes);
		exhausted = (cand_q >= top);
		accept    = in_valid && in_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_op == OP_SOLVE) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (at_end || (exhausted && d_q == '0)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (res_take && res.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res.valid = (state_q == ST_EMIT);
		res.found = !fail_q;
		res.node  = fail_q ? '0 : NODE_W'(k_q);
		res.color = fail_q ? '0 : rd_color;
		res.last  = fail_q || ((CNT_W'(k_q) + CNT_W'(1)) == lim.nodes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
			cand_q  <= '0;
			k_q     <= '0;
			fail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_op == OP_SOLVE) begin
						d_q    <= '0;
						cand_q <= '0;
						k_q    <= '0;
						fail_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (!at_end) begin
						if (exhausted) begin
							if (d_q == '0) begin
								fail_q <= 1'b1;
							end else begin
								d_q    <= d_dec;
								cand_q <= CNT_W'(rd_color) + CNT_W'(1);
							end
						end else if (fits) begin
							d_q    <= d_q + DW'(1);
							cand_q <= '0;
						end else begin
							cand_q <= cand_inc;
						end
					end
				end
				ST_EMIT: begin
					if (res_take) begin
						k_q <= k_q + IW'(1);
					end
				end
				default: fail_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				adj_q[r] <= '0;
			end
		end else if (accept && in_op == OP_LOAD
			&& CNT_W'(in_row) < CNT_W'(ROWS)) begin
			adj_q[in_row[IW-1:0]] <= in_bits[ROWS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH && !at_end && !exhausted && fits) begin
			stack_q[d_q[IW-1:0]] <= cand_q[COLOR_W-1:0];
			used_q[d_q + DW'(1)] <= used_new;
		end
	end

endmodule

// ===== verif/graph_coloring_backtrack_tb.sv =====
module graph_coloring_backtrack_tb;
	import gcb_pkg::*;

	localparam int STEP_BUDGET  = 1500;
	localparam int RANDOM_ITEMS = 420;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 10000000;

	typedef struct {
		logic              op;
		logic [3:0]        row;
		logic [ROW_W-1:0]  bits;
	} graph_word_t;

	typedef struct packed {
		logic               found;
		logic [NODE_W-1:0]  node;
		logic [COLOR_W-1:0] color;
		logic               last;
	} node_color_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [CFG_AW-1:0] paddr    = '0;
	logic [CFG_DW-1:0] pwdata   = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata  = '0;  // row_index [3:0], row_bits [19:4]
	logic              s_tuser  = 1'b0;  // operation
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;  // node [3:0], color [7:4]
	logic              m_tuser;  // found
	logic              m_tlast;

	graph_word_t word_q[$];
	node_color_t expected_colors[$];

	logic [MAX_ROWS-1:0][ROW_W-1:0] graph      = '0;
	logic [MAX_ROWS-1:0][ROW_W-1:0] plan_graph = '0;
	logic [CNT_W-1:0] cfg_colors = RST_COLORS;
	logic [CNT_W-1:0] cfg_nodes  = RST_NODES;

	graph_word_t next_word;
	node_color_t want, got;
	int gap_left = 0;
	int hold_left = 0;
	int stall;
	int taken = 0;
	bit squeezed = 1'b0;
	bit calm = 1'b0;
	int cycles = 0;
	int err_cnt = 0;
	int planned = 0;
	int load_cnt = 0;
	int solve_cnt = 0;
	int fail_cnt = 0;
	int checked_cnt = 0;

	graph_coloring_backtrack u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int clip(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Depth-first search: nodes in index order, colours in ascending order, and each node
	// tries at most one colour above the largest one already in use.
	function automatic bit search_coloring(input logic [MAX_ROWS-1:0][ROW_W-1:0] adj,
			input int n, input int m, output logic [MAX_ROWS-1:0][COLOR_W-1:0] cols,
			output int steps);
		int d, cand, top, c, p;
		bit placed, clash;
		cols = '0;
		steps = 0;
		d = 0;
		cand = 0;
		while (1) begin
			if (d == n) return 1'b1;
			if (steps > STEP_BUDGET) return 1'b0;
			top = 0;
			for (p = 0; p < d; p++)
				if (int'(cols[p]) + 1 > top) top = int'(cols[p]) + 1;
			top = clip(top + 1, 0, m);
			placed = 1'b0;
			for (c = cand; c < top && !placed; c++) begin
				steps++;
				clash = 1'b0;
				for (p = 0; p < d; p++)
					if (adj[p][d] && int'(cols[p]) == c) clash = 1'b1;
				if (!clash) begin
					cols[d] = c[COLOR_W-1:0];
					d++;
					cand = 0;
					placed = 1'b1;
				end
			end
			if (!placed) begin
				if (d == 0) return 1'b0;
				steps++;
				d--;
				cand = int'(cols[d]) + 1;
			end
		end
		return 1'b0;
	endfunction

	task automatic predict_word(input logic op, input logic [3:0] row,
			input logic [ROW_W-1:0] bits);
		logic [MAX_ROWS-1:0][COLOR_W-1:0] cols;
		node_color_t item;
		int n, m, steps, k;
		bit ok;
		if (op == OP_LOAD) begin
			graph[row] = bits;
			load_cnt++;
		end else begin
			n = clip(int'(cfg_nodes), 1, MAX_ROWS);
			m = clip(int'(cfg_colors), 0, int'(MAX_COLORS));
			ok = search_coloring(graph, n, m, cols, steps);
			solve_cnt++;
			if (!ok) begin
				fail_cnt++;
				item = '{found: 1'b0, node: '0, color: '0, last: 1'b1};
				expected_colors.push_back(item);
			end else begin
				for (k = 0; k < n; k++) begin
					item.found = 1'b1;
					item.node  = k[NODE_W-1:0];
					item.color = cols[k];
					item.last  = (k == n - 1);
					expected_colors.push_back(item);
				end
			end
		end
	endtask

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ROW_W-1:0] random_row(input int sparse);
		logic [ROW_W-1:0] r;
		r = 16'($urandom);
		case ($urandom_range(0, 3))
			0: r = r & 16'($urandom);
			1: r = r | 16'($urandom);
			default: ;
		endcase
		repeat (sparse / 3) r = r & 16'($urandom);
		return r;
	endfunction

	task automatic queue_load(input logic [3:0] row, input logic [ROW_W-1:0] bits);
		graph_word_t w;
		w.op = OP_LOAD;
		w.row = row;
		w.bits = bits;
		plan_graph[row] = bits;
		word_q.push_back(w);
		planned++;
	endtask

	task automatic queue_solve();
		graph_word_t w;
		w.op = OP_SOLVE;
		w.row = 4'($urandom);
		w.bits = 16'($urandom);
		word_q.push_back(w);
		planned++;
	endtask

	task automatic queue_cheap_solve();
		logic [MAX_ROWS-1:0][COLOR_W-1:0] cols;
		int steps;
		bit ok;
		ok = search_coloring(plan_graph, clip(int'(cfg_nodes), 1, MAX_ROWS),
			clip(int'(cfg_colors), 0, int'(MAX_COLORS)), cols, steps);
		if (steps <= STEP_BUDGET) queue_solve();
	endtask

	task automatic plan_full_set();
		logic [MAX_ROWS-1:0][ROW_W-1:0] trial;
		logic [MAX_ROWS-1:0][COLOR_W-1:0] cols;
		int n, m, steps, tries, i;
		bit ok;
		n = clip(int'(cfg_nodes), 1, MAX_ROWS);
		m = clip(int'(cfg_colors), 0, int'(MAX_COLORS));
		steps = STEP_BUDGET + 1;
		for (tries = 0; tries < 12 && steps > STEP_BUDGET; tries++) begin
			trial = plan_graph;
			for (i = 0; i < n; i++) trial[i] = random_row(tries);
			ok = search_coloring(trial, n, m, cols, steps);
		end
		if (steps > STEP_BUDGET)
			for (i = 0; i < n; i++) trial[i] = '0;
		if ($urandom_range(0, 1) == 0) begin
			for (i = 0; i < n; i++) queue_load(i[3:0], trial[i]);
		end else begin
			for (i = n - 1; i >= 0; i--) queue_load(i[3:0], trial[i]);
		end
		queue_solve();
	endtask

	task automatic settle();
		do @(negedge clk);
		while (word_q.size() != 0 || s_tvalid || expected_colors.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [CNT_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= CFG_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_COLORS) cfg_colors = value;
		else cfg_nodes = value;
	endtask

	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (word_q.size() != 0) begin
				next_word = word_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_word.op;
				s_tdata  <= {4'b0, next_word.bits, next_word.row};
				gap_left <= pick_gap(calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Once enough words have come back, the output is held off for a long stretch so that
	// the block fills up and stops taking input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) taken <= taken + 1;
			if (hold_left != 0) begin
				m_tready  <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!squeezed && taken >= 60 && word_q.size() > 8) begin
				squeezed  <= 1'b1;
				m_tready  <= 1'b0;
				hold_left <= LONG_HOLD;
			end else begin
				stall = pick_gap(calm);
				m_tready  <= (stall == 0);
				hold_left <= (stall == 0) ? 0 : stall - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.node  = m_tdata[3:0];
				got.color = m_tdata[7:4];
				got.last  = m_tlast;
				checked_cnt++;
				if (expected_colors.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected word found=%0d node=%0d colour=%0d last=%0d",
						$time, got.found, got.node, got.color, got.last);
				end else begin
					want = expected_colors.pop_front();
					if (got !== want) begin
						err_cnt++;
						$display("%0t: expected found=%0d node=%0d colour=%0d last=%0d", $time,
							want.found, want.node, want.color, want.last);
						$display("%0t: actual   found=%0d node=%0d colour=%0d last=%0d", $time,
							got.found, got.node, got.color, got.last);
					end
				end
			end
			if (s_tvalid && s_tready) predict_word(s_tuser, s_tdata[3:0], s_tdata[19:4]);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 97 == 0) calm <= ($urandom_range(0, 3) == 0);
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int r, i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset limits: an empty graph, then a full clique of four that three colours cannot
		// cover, then a triangle once node 0 is cut loose.
		queue_solve();
		queue_load(4'd0, 16'h000E);
		queue_load(4'd1, 16'h000D);
		queue_load(4'd2, 16'h000B);
		queue_load(4'd3, 16'h0007);
		queue_solve();
		queue_load(4'd15, 16'hFFFF);
		queue_load(4'd0, 16'h0000);
		queue_solve();
		settle();
		write_reg(REG_COLORS, 5'd0);
		write_reg(REG_NODES, 5'd31);
		queue_solve();
		settle();
		write_reg(REG_COLORS, 5'd31);
		write_reg(REG_NODES, 5'd16);
		queue_load(4'd0, 16'hFFFF);
		queue_solve();
		settle();
		write_reg(REG_NODES, 5'd0);
		queue_solve();
		settle();
		write_reg(REG_COLORS, 5'd1);
		write_reg(REG_NODES, 5'd2);
		queue_solve();
		settle();
		write_reg(REG_COLORS, 5'd2);
		queue_solve();

		planned = 0;
		while (planned < RANDOM_ITEMS) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 5) write_reg(REG_COLORS, 5'($urandom_range(1, 4)));
			else if (r < 7) write_reg(REG_COLORS, 5'($urandom_range(0, 16)));
			else if (r == 7) write_reg(REG_COLORS, MAX_COLORS);
			else if (r == 8) write_reg(REG_COLORS, 5'd0);
			else write_reg(REG_COLORS, 5'($urandom_range(17, 31)));
			r = $urandom_range(0, 9);
			if (r < 6) write_reg(REG_NODES, 5'($urandom_range(1, 6)));
			else if (r < 8) write_reg(REG_NODES, 5'($urandom_range(7, 12)));
			else if (r == 8) write_reg(REG_NODES, 5'($urandom_range(13, 16)));
			else write_reg(REG_NODES, ($urandom_range(0, 1) == 0) ? 5'd0
				: 5'($urandom_range(17, 31)));
			repeat ($urandom_range(3, 6)) begin
				case ($urandom_range(0, 9))
					7: begin
						for (i = 0; i < MAX_ROWS; i++)
							if ($urandom_range(0, 2) == 0) queue_load(i[3:0], random_row(0));
						queue_cheap_solve();
					end
					8: repeat ($urandom_range(1, 3))
						queue_load(4'($urandom_range(0, 15)), 16'($urandom));
					9: queue_cheap_solve();
					default: plan_full_set();
				endcase
			end
		end

		settle();
		repeat (20) @(negedge clk);
		$display("Covered %0d row loads and %0d searches, %0d of them without a colouring;",
			load_cnt, solve_cnt, fail_cnt);
		$display("%0d colour words checked under limits from zero to past sixteen.",
			checked_cnt);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
